FILE: hdl/ple_pkg.sv
package ple_pkg;

  // operation codes carried by a request
  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_COUNT    = 3'd6,
    OP_SEARCH   = 3'd7
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_OOB      = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 8;

  // one finished result, handed from the sequencer to the output register
  typedef struct packed {
    status_e                   status;
    logic signed [DataW-1:0]   removed;
    logic        [CountW-1:0]  found;
    logic        [CountW-1:0]  length;
  } res_t;

endpackage

FILE: hdl/ple_mem.sv
module ple_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AddrW-1:0]                waddr_i,
  input  logic signed [ple_pkg::DataW-1:0] wdata_i,
  input  logic [AddrW-1:0]                raddr_i,
  output logic signed [ple_pkg::DataW-1:0] rdata_o
);
  import ple_pkg::*;

  logic signed [DataW-1:0] mem_q [Depth];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ple_seq.sv
module ple_seq #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned AddrW    = 6,
  parameter int unsigned LenW     = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic [2:0]                       op_i,
  input  logic signed [ple_pkg::DataW-1:0] value_i,
  input  logic [7:0]                       position_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output ple_pkg::res_t                    res_o,
  output logic                             mem_we_o,
  output logic [AddrW-1:0]                 mem_waddr_o,
  output logic signed [ple_pkg::DataW-1:0] mem_wdata_o,
  output logic [AddrW-1:0]                 mem_raddr_o,
  input  logic signed [ple_pkg::DataW-1:0] mem_rdata_i
);
  import ple_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_WRITE = 6'b000100,
    S_DEL   = 6'b001000,
    S_SRCH  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [LenW-1:0]         len_q, len_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic [AddrW-1:0]        rptr_q, rptr_d;
  logic [AddrW-1:0]        tag_q, tag_d;
  logic [LenW-1:0]         cnt_q, cnt_d;
  logic                    pend_q, pend_d;
  logic                    first_q, first_d;
  status_e                 status_q, status_d;
  logic signed [DataW-1:0] removed_q, removed_d;
  logic [CountW-1:0]       found_q, found_d;

  logic [8:0] len9, pos9, idx9;
  op_e        op;

  assign op   = op_e'(op_i);
  assign len9 = 9'(len_q);
  assign pos9 = 9'(position_i);

  // target index of an insert or delete
  always_comb begin
    case (op)
      OP_APPEND:   idx9 = len9;
      OP_DEL_TAIL: idx9 = len9 - 9'd1;
      OP_INS_POS,
      OP_DEL_POS:  idx9 = pos9 - 9'd1;
      default:     idx9 = 9'd0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    val_d       = val_q;
    idx_d       = idx_q;
    rptr_d      = rptr_q;
    tag_d       = tag_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    first_d     = first_q;
    status_d    = status_q;
    removed_d   = removed_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AddrW'(tag_q + 1'b1);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = rptr_q;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          status_d  = ST_OK;
          removed_d = '0;
          found_d   = '0;
          val_d     = value_i;
          idx_d     = AddrW'(idx9);
          pend_d    = 1'b0;
          first_d   = 1'b1;
          state_d   = S_DONE;
          case (op)
            OP_APPEND, OP_INS_HEAD, OP_INS_POS: begin
              if (op == OP_INS_POS && position_i == 8'd0) begin
                status_d = ST_INVALID;
              end else if (op == OP_INS_POS && pos9 > len9 + 9'd1) begin
                status_d = ST_OOB;
              end else if (len9 >= 9'(Capacity)) begin
                status_d = ST_FULL;
              end else begin
                // shift the tail down one place, last entry first
                cnt_d   = LenW'(len9 - idx9);
                rptr_d  = AddrW'(len9 - 9'd1);
                state_d = (len9 == idx9) ? S_WRITE : S_SHIFT;
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
              if (len_q == '0) begin
                status_d = ST_EMPTY;
              end else if (op == OP_DEL_POS && position_i == 8'd0) begin
                status_d = ST_INVALID;
              end else if (op == OP_DEL_POS && pos9 > len9) begin
                status_d = ST_OOB;
              end else begin
                // first read returns the removed value, the rest move up
                cnt_d   = LenW'(len9 - idx9);
                rptr_d  = AddrW'(idx9);
                state_d = S_DEL;
              end
            end
            OP_SEARCH: begin
              if (len_q == '0) begin
                status_d = ST_NOTFOUND;
              end else begin
                cnt_d   = len_q;
                rptr_d  = '0;
                state_d = S_SRCH;
              end
            end
            default: ;
          endcase
        end
      end

      S_SHIFT: begin
        if (pend_q) begin
          mem_we_o = 1'b1;
        end
        if (cnt_q != '0) begin
          tag_d  = rptr_q;
          rptr_d = AddrW'(rptr_q - 1'b1);
          cnt_d  = LenW'(cnt_q - 1'b1);
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_WRITE;
        end
      end

      S_WRITE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = val_q;
        len_d       = LenW'(len_q + 1'b1);
        state_d     = S_DONE;
      end

      S_DEL: begin
        mem_waddr_o = AddrW'(tag_q - 1'b1);
        if (pend_q) begin
          if (first_q) begin
            removed_d = mem_rdata_i;
            first_d   = 1'b0;
          end else begin
            mem_we_o = 1'b1;
          end
        end
        if (cnt_q != '0) begin
          tag_d  = rptr_q;
          rptr_d = AddrW'(rptr_q + 1'b1);
          cnt_d  = LenW'(cnt_q - 1'b1);
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          len_d   = LenW'(len_q - 1'b1);
          state_d = S_DONE;
        end
      end

      S_SRCH: begin
        if (pend_q && mem_rdata_i == val_q) begin
          found_d  = CountW'(tag_q) + CountW'(1);
          status_d = ST_OK;
          pend_d   = 1'b0;
          state_d  = S_DONE;
        end else if (cnt_q == '0) begin
          status_d = ST_NOTFOUND;
          pend_d   = 1'b0;
          state_d  = S_DONE;
        end else begin
          tag_d  = rptr_q;
          rptr_d = AddrW'(rptr_q + 1'b1);
          cnt_d  = LenW'(cnt_q - 1'b1);
          pend_d = 1'b1;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      pend_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    idx_q     <= idx_d;
    rptr_q    <= rptr_d;
    tag_q     <= tag_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
  end

  assign req_ready_o    = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE);
  assign res_o.status   = status_q;
  assign res_o.removed  = removed_q;
  assign res_o.found    = found_q;
  assign res_o.length   = CountW'(len_q);

endmodule

FILE: hdl/positional_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit values, kept dense in list
// order in one single-port-write memory with a registered read. Each request
// carries one operation (append, insert at head or at a 1-based position,
// delete first, last or at a position, count, search) and gives exactly one
// result with status, removed value, found position and the length after the
// operation. Inserts and deletes move the entries behind the target index and
// a search compares entries from the head until it finds a match; the
// sequencer moves or compares one memory entry per cycle through the single
// read port. One request is in flight at a time;
// the next request is taken as soon as the result sits in the output register,
// even if the consumer has not yet taken it. Memory contents need no clearing
// after reset: only entries below the current length are ever read.
module positional_list_engine_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       op_i,
  input  logic signed [ple_pkg::DataW-1:0] value_i,
  input  logic [7:0]                       position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       status_o,
  output logic signed [ple_pkg::DataW-1:0] removed_value_o,
  output logic [7:0]                       found_position_o,
  output logic [7:0]                       length_o
);
  import ple_pkg::*;

  // address width for the entry memory, length counter holds 0..CAPACITY
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LenW  = $clog2(CAPACITY + 1);

  // sequencer to memory
  logic                    mem_we;
  logic [AddrW-1:0]        mem_waddr;
  logic signed [DataW-1:0] mem_wdata;
  logic [AddrW-1:0]        mem_raddr;
  logic signed [DataW-1:0] mem_rdata;

  // sequencer to output register
  logic res_valid;
  logic res_ready;
  res_t res;

  // output register
  logic out_valid_q;
  res_t out_q;

  // shifts read entry i and write entry i+1 (or i-1) in the following cycle, so a
  // read never meets a write to the same entry and no forwarding is needed
  ple_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ple_seq #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .LenW     (LenW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output stage frees the sequencer while a result waits for the consumer
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = 3'(out_q.status);
  assign removed_value_o  = out_q.removed;
  assign found_position_o = out_q.found;
  assign length_o         = out_q.length;

endmodule

FILE: test/list_check_pkg.sv
package list_check_pkg;

  import ple_pkg::*;

  // mirror of the list contents plus the results still owed by the block
  class list_checker;
    int unsigned             capacity;
    logic signed [DataW-1:0] entries[$];
    res_t                    pending_results[$];
    int unsigned             mismatches;

    function new(int unsigned cap);
      capacity   = cap;
      mismatches = 0;
    endfunction

    function int unsigned length_now();
      return entries.size();
    endfunction

    function logic signed [DataW-1:0] entry_at(int unsigned idx);
      return entries[idx];
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function status_e place_entry(int unsigned idx, logic signed [DataW-1:0] v);
      if (entries.size() >= capacity) begin
        return ST_FULL;
      end
      if (idx >= entries.size()) begin
        entries.push_back(v);
      end else begin
        entries.insert(idx, v);
      end
      return ST_OK;
    endfunction

    // apply one accepted request and queue the result it must give
    function void note_request(op_e op, logic signed [DataW-1:0] v, logic [7:0] pos);
      res_t        want;
      int unsigned n;
      want.status  = ST_OK;
      want.removed = '0;
      want.found   = '0;
      n = entries.size();
      case (op)
        OP_APPEND: begin
          want.status = place_entry(n, v);
        end
        OP_INS_HEAD: begin
          want.status = place_entry(0, v);
        end
        OP_INS_POS: begin
          if (pos == 0) want.status = ST_INVALID;
          else if (pos > n + 1) want.status = ST_OOB;
          else want.status = place_entry(pos - 1, v);
        end
        OP_DEL_HEAD: begin
          if (n == 0) want.status = ST_EMPTY;
          else want.removed = entries.pop_front();
        end
        OP_DEL_TAIL: begin
          if (n == 0) want.status = ST_EMPTY;
          else want.removed = entries.pop_back();
        end
        OP_DEL_POS: begin
          if (n == 0) want.status = ST_EMPTY;
          else if (pos == 0) want.status = ST_INVALID;
          else if (pos > n) want.status = ST_OOB;
          else begin
            want.removed = entries[pos - 1];
            entries.delete(pos - 1);
          end
        end
        OP_COUNT: begin
          want.status = ST_OK;
        end
        default: begin
          want.status = ST_NOTFOUND;
          for (int unsigned i = 0; i < n; i++) begin
            if (entries[i] == v) begin
              want.status = ST_OK;
              want.found  = CountW'(i + 1);
              break;
            end
          end
        end
      endcase
      want.length = CountW'(entries.size());
      pending_results.push_back(want);
    endfunction

    // compare one result from the block with the oldest owed result
    function void check_result(logic [2:0] st, logic signed [DataW-1:0] rem,
                               logic [7:0] fnd, logic [7:0] len);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d removed %0d found %0d length %0d",
                   st, rem, fnd, len);
        end
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status || rem !== want.removed ||
          fnd !== want.found || len !== want.length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected status %0d removed %0d found %0d length %0d",
                   want.status, want.removed, want.found, want.length);
          $display("          actual   status %0d removed %0d found %0d length %0d",
                   st, rem, fnd, len);
        end
      end
    endfunction
  endclass

endpackage

FILE: test/tb_positional_list_engine_top.sv
module tb_positional_list_engine_top;

  import ple_pkg::*;
  import list_check_pkg::*;

  localparam int unsigned Capacity       = 64;
  localparam int unsigned RandomRequests = 900;
  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned DrainCycles    = 200;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [2:0]              op;
  logic signed [DataW-1:0] value;
  logic [7:0]              position;
  logic                    out_valid;
  logic                    out_ready;
  logic [2:0]              status;
  logic signed [DataW-1:0] removed_value;
  logic [7:0]              found_position;
  logic [7:0]              length;

  list_checker board;
  bit          steady;        // when set, neither side idles
  bit          growing;       // random phase that fills the list, else drains it
  int unsigned cycles = 0;

  positional_list_engine_top #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .value_i         (value),
    .position_i      (position),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .removed_value_o (removed_value),
    .found_position_o(found_position),
    .length_o        (length)
  );

  // clock, period 20
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL positional_list_engine_top");
      $finish;
    end
  end

  // result monitor, outputs sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(status, removed_value, found_position, length);
    end
  end

  // gap before a request: mostly none or short, now and then long
  function automatic int unsigned request_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // consumer side: bursts of ready and stall, mostly short, a few long
  initial begin
    int unsigned hold;
    bit          level;
    hold  = 0;
    level = 1'b1;
    forever begin
      @(negedge clk);
      if (steady) begin
        hold = 0;
        out_ready <= 1'b1;
      end else begin
        if (hold == 0) begin
          level = ($urandom_range(0, 2) != 0);
          hold  = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 4)
                                               : $urandom_range(15, 60);
        end
        hold--;
        out_ready <= level;
      end
    end
  end

  // drive one request at the falling edge and hold it until accepted
  task automatic send_request(op_e o, logic signed [DataW-1:0] v, logic [7:0] p);
    int unsigned gap;
    gap = steady ? 0 : request_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    position <= p;
    do @(posedge clk); while (!in_ready);
    board.note_request(o, v, p);
  endtask

  // values: small ones for duplicates, the extremes, and full-range noise
  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 8) - 4;
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  // one random request shaped by the current phase and list length
  task automatic random_request();
    int unsigned             n;
    int unsigned             r;
    op_e                     o;
    logic signed [DataW-1:0] v;
    logic [7:0]              p;
    n = board.length_now();
    v = pick_value();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: any op, any position
      o = op_e'(3'($urandom_range(0, 7)));
      p = 8'($urandom_range(0, 255));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        o = growing ? op_e'(3'($urandom_range(0, 2))) : op_e'(3'($urandom_range(3, 5)));
      end else if (r < 80) begin
        o = growing ? op_e'(3'($urandom_range(3, 5))) : op_e'(3'($urandom_range(0, 2)));
      end else begin
        o = ($urandom_range(0, 3) == 0) ? OP_COUNT : OP_SEARCH;
      end
      // positions: mostly legal, plus zero, the last legal one and beyond the end
      case ($urandom_range(0, 9))
        0: p = 8'd0;
        1: p = 8'($urandom_range(n + 2, 255));
        2: p = 8'((o == OP_INS_POS) ? n + 1 : ((n > 0) ? n : 1));
        3: p = 8'd1;
        default: p = 8'((o == OP_INS_POS) ? $urandom_range(1, n + 1)
                                          : $urandom_range(1, (n > 0) ? n : 1));
      endcase
    end
    // searches mostly look for a value that is held
    if (o == OP_SEARCH && n > 0 && $urandom_range(0, 2) != 0) begin
      v = board.entry_at($urandom_range(0, n - 1));
    end
    send_request(o, v, p);
  endtask

  initial begin
    int unsigned held_at_end;
    board     = new(Capacity);
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    op        = OP_COUNT;
    value     = '0;
    position  = '0;
    out_ready = 1'b0;
    steady    = 1'b0;
    growing   = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list corners
    send_request(OP_COUNT,    '0, 8'd0);
    send_request(OP_DEL_HEAD, '0, 8'd0);
    send_request(OP_DEL_TAIL, '0, 8'd0);
    send_request(OP_DEL_POS,  '0, 8'd0);   // empty wins over bad position
    send_request(OP_SEARCH,   5, 8'd0);    // search on empty misses
    send_request(OP_INS_POS,  3, 8'd0);    // position zero
    send_request(OP_INS_POS,  3, 8'd2);    // past length + 1
    // build a short list, positional insert at head, tail and middle
    send_request(OP_INS_POS,  32'sh7fffffff, 8'd1);
    send_request(OP_INS_HEAD, 32'sh80000000, 8'd0);
    send_request(OP_APPEND,   -1, 8'd0);
    send_request(OP_INS_POS,  7, 8'd4);
    send_request(OP_INS_POS,  7, 8'd2);
    send_request(OP_INS_POS,  9, 8'd255);
    // search hits first of duplicates, head, and a miss
    send_request(OP_SEARCH,   7, 8'd0);
    send_request(OP_SEARCH,   32'sh80000000, 8'd0);
    send_request(OP_SEARCH,   12345, 8'd0);
    // delete corners then drain
    send_request(OP_DEL_POS,  '0, 8'd0);
    send_request(OP_DEL_POS,  '0, 8'd6);
    send_request(OP_DEL_POS,  '0, 8'd255);
    send_request(OP_DEL_POS,  '0, 8'd2);
    send_request(OP_DEL_TAIL, '0, 8'd0);
    send_request(OP_DEL_HEAD, '0, 8'd0);
    send_request(OP_DEL_POS,  '0, 8'd2);
    send_request(OP_DEL_POS,  '0, 8'd1);
    send_request(OP_COUNT,    '0, 8'd0);

    // random: alternate fill and drain phases so full and empty recur
    held_at_end = 0;
    for (int unsigned i = 0; i < RandomRequests; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      random_request();
      if (growing && board.length_now() == Capacity) held_at_end++;
      if (!growing && board.length_now() == 0) held_at_end++;
      if (held_at_end >= 4) begin
        growing     = ~growing;
        held_at_end = 0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // wait for owed results, then let the block settle
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("PASS positional_list_engine_top");
    end else begin
      $display("FAIL positional_list_engine_top");
    end
    $finish;
  end

endmodule
